// ===== hw/rtl/ffca_pkg.sv =====
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types and constants of the first-fit coalescing allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

  localparam int MAX_SEGMENTS   = 64;
  localparam int SEG_AW         = 6;
  localparam int CNT_W          = 7;
  localparam int POOL_MAX_BYTES = 65536;
  localparam int HEADER_BYTES   = 12;
  localparam int STORE_DEPTH    = POOL_MAX_BYTES / 4 + 1;
  localparam int STORE_AW       = 15;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NO_FIT   = 3'd2,
    ST_OUTSIDE  = 3'd3,
    ST_FULL     = 3'd4,
    ST_SMALL    = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    RS_IDX  = 2'd0,
    RS_UP   = 2'd1,
    RS_DOWN = 2'd2
  } rsel_e;

  typedef enum logic [2:0] {
    WS_INIT  = 3'd0,
    WS_SPLIT = 3'd1,
    WS_SHIFT = 3'd2,
    WS_PREV  = 3'd3,
    WS_NEXT  = 3'd4,
    WS_NEW   = 3'd5
  } wsel_e;

  typedef struct packed {
    logic    load_in;
    logic    init_commit;
    logic    st_en;
    status_e st_val;
    logic    prep;
    logic    idx_clr;
    logic    idx_inc;
    logic    seg_re;
    rsel_e   rsel;
    logic    seg_we;
    wsel_e   wsel;
    logic    hit_latch;
    logic    take;
    logic    j_from_idx;
    logic    j_from_cnt;
    logic    j_inc;
    logic    j_dec;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    store_re;
    logic    prev_latch;
    logic    cur_latch;
    logic    free_commit;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic req_zero;
    logic free_reject;
    logic init_fail;
    logic idx_end;
    logic fit;
    logic whole;
    logic found;
    logic jn;
    logic jp;
    logic full;
    logic j_at_p;
    logic rm_end;
  } sts_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? (a - b) : 32'd0;
  endfunction

endpackage

// ===== hw/rtl/ffca_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffca_ctrl
// Sequencer of the allocator: walks the segment table and drives the datapath.
// ----------------------------------------------------------------------------
module ffca_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_free,
  output logic          res_load,
  input  ffca_pkg::sts_t sts,
  output ffca_pkg::cmd_t cmd
);
  import ffca_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_DECODE = 14'b00000000000010,
    S_A_RD   = 14'b00000000000100,
    S_A_CHK  = 14'b00000000001000,
    S_A_TAKE = 14'b00000000010000,
    S_RM_RD  = 14'b00000000100000,
    S_RM_WR  = 14'b00000001000000,
    S_F_SZ   = 14'b00000010000000,
    S_F_RD   = 14'b00000100000000,
    S_F_CHK  = 14'b00001000000000,
    S_F_DEC  = 14'b00010000000000,
    S_INS_RD = 14'b00100000000000,
    S_INS_WR = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        unique case (sts.op)
          OP_INIT: begin
            if (sts.init_fail) begin
              cmd.st_en  = 1'b1;
              cmd.st_val = ST_SMALL;
            end else begin
              cmd.init_commit = 1'b1;
              cmd.seg_we      = 1'b1;
              cmd.wsel        = WS_INIT;
            end
          end
          OP_ALLOC: begin
            if (sts.req_zero) begin
              cmd.st_en  = 1'b1;
              cmd.st_val = ST_ZERO;
            end else begin
              cmd.prep    = 1'b1;
              cmd.idx_clr = 1'b1;
              state_next  = S_A_RD;
            end
          end
          OP_FREE: begin
            if (sts.free_reject) begin
              cmd.st_en  = 1'b1;
              cmd.st_val = ST_OUTSIDE;
            end else begin
              cmd.prep    = 1'b1;
              cmd.idx_clr = 1'b1;
              state_next  = S_F_SZ;
            end
          end
          default: begin
          end
        endcase
      end
      S_A_RD: begin
        if (sts.idx_end) begin
          cmd.st_en  = 1'b1;
          cmd.st_val = ST_NO_FIT;
          state_next = S_DONE;
        end else begin
          cmd.seg_re = 1'b1;
          cmd.rsel   = RS_IDX;
          state_next = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (sts.fit) begin
          cmd.hit_latch = 1'b1;
          state_next    = S_A_TAKE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_A_RD;
        end
      end
      S_A_TAKE: begin
        cmd.take = 1'b1;
        if (sts.whole) begin
          cmd.j_from_idx = 1'b1;
          state_next     = S_RM_RD;
        end else begin
          cmd.seg_we = 1'b1;
          cmd.wsel   = WS_SPLIT;
          state_next = S_DONE;
        end
      end
      S_RM_RD: begin
        if (sts.rm_end) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.seg_re = 1'b1;
          cmd.rsel   = RS_UP;
          state_next = S_RM_WR;
        end
      end
      S_RM_WR: begin
        cmd.seg_we = 1'b1;
        cmd.wsel   = WS_SHIFT;
        cmd.j_inc  = 1'b1;
        state_next = S_RM_RD;
      end
      S_F_SZ: begin
        cmd.store_re = 1'b1;
        state_next   = S_F_RD;
      end
      S_F_RD: begin
        if (sts.idx_end) begin
          state_next = S_F_DEC;
        end else begin
          cmd.seg_re = 1'b1;
          cmd.rsel   = RS_IDX;
          state_next = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (sts.found) begin
          cmd.cur_latch = 1'b1;
          state_next    = S_F_DEC;
        end else begin
          cmd.prev_latch = 1'b1;
          cmd.idx_inc    = 1'b1;
          state_next     = S_F_RD;
        end
      end
      S_F_DEC: begin
        state_next = S_DONE;
        if (!sts.jn && !sts.jp && sts.full) begin
          cmd.st_en  = 1'b1;
          cmd.st_val = ST_FULL;
        end else begin
          cmd.free_commit = 1'b1;
          if (sts.jp) begin
            cmd.seg_we = 1'b1;
            cmd.wsel   = WS_PREV;
            if (sts.jn) begin
              cmd.j_from_idx = 1'b1;
              state_next     = S_RM_RD;
            end
          end else if (sts.jn) begin
            cmd.seg_we = 1'b1;
            cmd.wsel   = WS_NEXT;
          end else begin
            cmd.j_from_cnt = 1'b1;
            state_next     = S_INS_RD;
          end
        end
      end
      S_INS_RD: begin
        if (sts.j_at_p) begin
          cmd.seg_we  = 1'b1;
          cmd.wsel    = WS_NEW;
          cmd.cnt_inc = 1'b1;
          state_next  = S_DONE;
        end else begin
          cmd.seg_re = 1'b1;
          cmd.rsel   = RS_DOWN;
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.seg_we = 1'b1;
        cmd.wsel   = WS_SHIFT;
        cmd.j_dec  = 1'b1;
        state_next = S_INS_RD;
      end
      S_DONE: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/ffca_dp.sv =====
// ----------------------------------------------------------------------------
// ffca_dp
// Datapath: segment table, block size store, counters and arithmetic.
// ----------------------------------------------------------------------------
module ffca_dp (
  input  logic           clk,
  input  logic           rst,
  input  ffca_pkg::cmd_t cmd,
  output ffca_pkg::sts_t sts,
  input  logic [1:0]     opcode,
  input  logic [16:0]    request_bytes,
  input  logic [31:0]    block_address,
  input  logic [31:0]    pool_start,
  input  logic [16:0]    pool_bytes,
  input  logic [7:0]     align_bytes,
  output logic [2:0]     res_status,
  output logic [31:0]    res_address,
  output logic [16:0]    res_free
);
  import ffca_pkg::*;

  logic [63:0] seg_mem [MAX_SEGMENTS];
  logic [31:0] store_mem [STORE_DEPTH];
  logic [63:0] seg_rd;
  logic [31:0] store_rd;

  op_e         op_q;
  logic [16:0] req_q;
  logic [31:0] blk_q;
  logic [31:0] need, off_q, len_q;
  logic [31:0] prev_off, prev_len, cur_off, cur_len;
  logic [CNT_W-1:0] idx, jdx, count;
  logic [31:0] total, base, plen;
  status_e     status_q;
  logic [31:0] addr_q;

  // granule and mask
  logic [7:0]  gran, mask;
  assign gran = (align_bytes == 8'd0) ? 8'd4 : align_bytes;
  assign mask = gran - 8'd1;

  // init arithmetic
  logic [33:0] start0, up, skip, start1, end_c, mask34;
  logic [33:0] size0, size1;
  logic        mis;
  logic [31:0] plen_c;
  assign mask34 = {26'd0, mask};
  assign start0 = {2'b00, pool_start};
  assign mis    = |(pool_start[7:0] & mask);
  assign up     = (start0 + mask34) & ~mask34;
  assign skip   = up - start0;
  assign size0  = (pool_bytes > 17'(POOL_MAX_BYTES)) ? 34'(POOL_MAX_BYTES)
                                                     : {17'd0, pool_bytes};
  assign size1  = !mis ? size0 : ((size0 < skip) ? 34'd0 : size0 - skip);
  assign start1 = mis ? up : start0;
  assign end_c  = (start1 + size1) & ~mask34;
  assign plen_c = (end_c > start1) ? 32'(end_c - start1) : 32'd0;

  // alloc arithmetic
  logic [31:0] need0, need_c, left;
  assign need0  = {15'd0, req_q} + 32'(HEADER_BYTES);
  assign need_c = ((need0 & {24'd0, mask}) != 32'd0) ?
                  ((need0 + {24'd0, mask}) & ~{24'd0, mask}) : need0;
  assign left   = len_q - need;

  // free arithmetic
  logic [32:0] floor_c, foff33;
  assign floor_c = {1'b0, base} + 33'(HEADER_BYTES);
  assign foff33  = {1'b0, blk_q} - floor_c;

  logic [31:0] size_w;
  assign size_w = store_rd;

  logic [31:0] prev_new, next_new;
  assign prev_new = sts.jn ? sat_add(sat_add(prev_len, size_w), cur_len)
                           : sat_add(prev_len, size_w);
  assign next_new = sat_add(cur_len, size_w);

  always_comb begin
    sts.op          = op_q;
    sts.req_zero    = (req_q == 17'd0);
    sts.free_reject = ({1'b0, blk_q} < floor_c) || (foff33 >= {1'b0, plen});
    sts.init_fail   = (size1 < {26'd0, gran});
    sts.idx_end     = (idx >= count);
    sts.fit         = (seg_rd[31:0] >= need);
    sts.whole       = ({1'b0, left} < ({25'd0, gran} + 33'(HEADER_BYTES)));
    sts.found       = (seg_rd[63:32] >= off_q);
    sts.jn          = (idx < count) &&
                      (({1'b0, off_q} + {1'b0, size_w}) == {1'b0, cur_off});
    sts.jp          = (idx != '0) &&
                      (({1'b0, prev_off} + {1'b0, prev_len}) == {1'b0, off_q});
    sts.full        = (count >= CNT_W'(MAX_SEGMENTS));
    sts.j_at_p      = (jdx == idx);
    sts.rm_end      = ((jdx + CNT_W'(1)) >= count);
  end

  // segment table ports
  logic [SEG_AW-1:0] raddr, waddr;
  logic [63:0]       wdata;
  logic [CNT_W-1:0]  jup, jdn, idm;
  assign jup = jdx + CNT_W'(1);
  assign jdn = jdx - CNT_W'(1);
  assign idm = idx - CNT_W'(1);

  always_comb begin
    case (cmd.rsel)
      RS_UP:   raddr = jup[SEG_AW-1:0];
      RS_DOWN: raddr = jdn[SEG_AW-1:0];
      default: raddr = idx[SEG_AW-1:0];
    endcase
    case (cmd.wsel)
      WS_INIT:  begin waddr = '0;                 wdata = {32'd0, plen_c}; end
      WS_SPLIT: begin waddr = idx[SEG_AW-1:0];    wdata = {off_q + need, left}; end
      WS_SHIFT: begin waddr = jdx[SEG_AW-1:0];    wdata = seg_rd; end
      WS_PREV:  begin waddr = idm[SEG_AW-1:0];    wdata = {prev_off, prev_new}; end
      WS_NEXT:  begin waddr = idx[SEG_AW-1:0];    wdata = {off_q, next_new}; end
      default:  begin waddr = idx[SEG_AW-1:0];    wdata = {off_q, size_w}; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_we) begin
      seg_mem[waddr] <= wdata;
    end
    if (cmd.seg_re) begin
      seg_rd <= seg_mem[raddr];
    end
  end

  // block size store
  logic [STORE_AW-1:0] sidx;
  assign sidx = (off_q[31:16] != 16'd0) ? STORE_AW'(STORE_DEPTH - 1)
                                        : {1'b0, off_q[15:2]};

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      store_mem[sidx] <= sts.whole ? len_q : need;
    end
    if (cmd.store_re) begin
      store_rd <= store_mem[sidx];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q  <= op_e'(opcode);
      req_q <= request_bytes;
      blk_q <= block_address;
    end
    if (cmd.prep) begin
      need  <= need_c;
      off_q <= foff33[31:0];
    end
    if (cmd.hit_latch) begin
      off_q <= seg_rd[63:32];
      len_q <= seg_rd[31:0];
    end
    if (cmd.prev_latch) begin
      prev_off <= seg_rd[63:32];
      prev_len <= seg_rd[31:0];
    end
    if (cmd.cur_latch) begin
      cur_off <= seg_rd[63:32];
      cur_len <= seg_rd[31:0];
    end
    if (cmd.load_in) begin
      status_q <= ST_OK;
      addr_q   <= 32'd0;
    end else if (cmd.st_en) begin
      status_q <= cmd.st_val;
    end
    if (cmd.take) begin
      addr_q <= base + off_q + 32'(HEADER_BYTES);
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + CNT_W'(1);
    end
    if (cmd.j_from_idx) begin
      jdx <= idx;
    end else if (cmd.j_from_cnt) begin
      jdx <= count;
    end else if (cmd.j_inc) begin
      jdx <= jup;
    end else if (cmd.j_dec) begin
      jdx <= jdn;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= '0;
      base  <= '0;
      plen  <= '0;
    end else begin
      if (cmd.init_commit) begin
        count <= CNT_W'(1);
        total <= plen_c;
        base  <= start1[31:0];
        plen  <= plen_c;
      end else if (cmd.cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.take) begin
        total <= sts.whole ? sat_sub(total, len_q) : sat_sub(total, need);
      end else if (cmd.free_commit) begin
        total <= sat_add(total, size_w);
      end
    end
  end

  assign res_status  = status_q;
  assign res_address = addr_q;
  assign res_free    = (total > 32'h1FFFF) ? 17'h1FFFF : total[16:0];

endmodule

// ===== hw/rtl/first_fit_coalescing_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator
// First-fit heap allocator with free-segment coalescing over one pool.
// ----------------------------------------------------------------------------
// Usage: program pool_start (0x0), pool_bytes (0x4) and align_bytes (0x8)
// over the APB port while idle, then send an init transfer (opcode 0).
// Allocate (1) takes request_bytes, free (2) takes block_address.
// Each input transfer yields exactly one result transfer with status,
// user_address and free_bytes.
// Init, zero requests and out-of-pool frees are settled in the decode state
// and go straight to the result. Allocate reads the segments one by one
// until one fits, then shifts the later entries down when a segment is
// consumed; free reads the segments up to the insertion point, then shifts
// entries up to insert a new one, or down when two segments merge. All scans
// go through the single read port of the 64-entry segment table.
// One item is processed at a time; a new item is taken while the previous
// result waits in the output register.
// Reset empties the segment table and clears the free total and base; the
// size store needs no clearing. If the receiver stalls, the result holds
// and the block stalls after finishing the next item.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [16:0] request_bytes,
  input  logic [31:0] block_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] user_address,
  output logic [16:0] free_bytes
);
  import ffca_pkg::*;

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_BYTES = 2'd1,
    REG_ALIGN = 2'd2
  } reg_e;

  logic [31:0] pool_start;
  logic [16:0] pool_bytes;
  logic [7:0]  align_bytes;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_start  <= '0;
      pool_bytes  <= '0;
      align_bytes <= 8'd4;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_START: pool_start  <= pwdata;
        REG_BYTES: pool_bytes  <= pwdata[16:0];
        REG_ALIGN: align_bytes <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START: prdata = pool_start;
      REG_BYTES: prdata = {15'd0, pool_bytes};
      REG_ALIGN: prdata = {24'd0, align_bytes};
      default:   prdata = 32'd0;
    endcase
  end

  cmd_t        cmd;
  sts_t        sts;
  logic        out_free, res_load;
  logic [2:0]  res_status;
  logic [31:0] res_address;
  logic [16:0] res_free;

  assign out_free = !out_valid || out_ready;

  ffca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .res_load (res_load),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffca_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .opcode        (opcode),
    .request_bytes (request_bytes),
    .block_address (block_address),
    .pool_start    (pool_start),
    .pool_bytes    (pool_bytes),
    .align_bytes   (align_bytes),
    .res_status    (res_status),
    .res_address   (res_address),
    .res_free      (res_free)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status       <= res_status;
      user_address <= res_address;
      free_bytes   <= res_free;
    end
  end

endmodule

// ===== test/first_fit_coalescing_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator_tb
// Self-checking testbench of the first-fit coalescing allocator. A directed
// table covers reset behavior, rejects and pool-edge cases. A fragmentation
// phase then frees isolated blocks until the segment table overflows, and
// random phases follow, each with its own pool setup. Every result is checked
// against an in-bench allocator model, or against the table for typed rows,
// with random gaps on input and random output stalls.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffca_pkg::*;

  typedef enum int {REG_POOL_START = 0, REG_POOL_BYTES = 1, REG_ALIGN = 2} reg_e;
  typedef enum int {ROW_ITEM, ROW_CFG} row_e;
  typedef enum int {ADDR_FIXED, ADDR_LAST} asel_e;

  typedef struct {
    status_e     st;
    logic [31:0] ua;
    logic [16:0] fb;
  } result_t;

  typedef struct {
    row_e        kind;
    op_e         op;
    logic [16:0] req;   // register index for ROW_CFG
    logic [31:0] addr;  // register value for ROW_CFG
    asel_e       asel;
    bit          typed;
    status_e     st;
    logic [31:0] ua;
    logic [16:0] fb;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = '0;
  logic [16:0] request_bytes = '0;
  logic [31:0] block_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [31:0] user_address;
  logic [16:0] free_bytes;

  first_fit_coalescing_allocator dut (.*);

  always #5 clk = ~clk;

  // allocator model state
  logic [31:0] m_start = '0;
  logic [16:0] m_bytes = '0;
  logic [7:0]  m_align = 8'd4;
  logic [31:0] seg_off [0:MAX_SEGMENTS-1];
  logic [31:0] seg_len [0:MAX_SEGMENTS-1];
  int          seg_cnt = 0;
  logic [31:0] free_tot = '0;
  logic [31:0] base = '0;
  logic [31:0] plen = '0;
  logic [31:0] size_store [0:STORE_DEPTH-1];
  bit          written [0:STORE_DEPTH-1];
  logic [31:0] last_addr = '0;
  logic [31:0] live_q [$];

  result_t     exp_q [$];
  int          errors = 0;
  int          sent = 0;
  int          checked = 0;
  int          st_hist [0:7];
  int          hold_req = 0;

  function automatic longint unsigned granule();
    return (m_align == 0) ? 64'd4 : 64'(m_align);
  endfunction

  function automatic int sidx(logic [31:0] off);
    return (off >> 2) < STORE_DEPTH ? int'(off >> 2) : STORE_DEPTH - 1;
  endfunction

  function automatic logic [31:0] sadd(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void drop_seg(int p);
    for (int i = p; i + 1 < seg_cnt; i++) begin
      seg_off[i] = seg_off[i+1];
      seg_len[i] = seg_len[i+1];
    end
    seg_cnt--;
  endfunction

  function automatic status_e pool_init();
    longint unsigned mask, start, size, up, endv;
    mask  = granule() - 1;
    start = 64'(m_start);
    size  = (m_bytes > POOL_MAX_BYTES) ? POOL_MAX_BYTES : 64'(m_bytes);
    if ((start & mask) != 0) begin
      up    = (start + mask) & ~mask;
      size  = (size < up - start) ? 0 : size - (up - start);
      start = up;
    end
    if (size < granule()) return ST_SMALL;
    endv       = (start + size) & ~mask;
    base       = start[31:0];
    plen       = (endv > start) ? 32'(endv - start) : 32'd0;
    free_tot   = plen;
    seg_off[0] = 0;
    seg_len[0] = plen;
    seg_cnt    = 1;
    live_q.delete();
    return ST_OK;
  endfunction

  function automatic status_e pool_alloc(logic [16:0] req, output logic [31:0] ua);
    logic [31:0] need, mask, off, len, left;
    int i;
    ua = 0;
    if (req == 0) return ST_ZERO;
    mask = 32'(granule() - 1);
    need = 32'(req) + HEADER_BYTES;
    if ((need & mask) != 0) need = (need + mask) & ~mask;
    for (i = 0; i < seg_cnt; i++)
      if (seg_len[i] >= need) break;
    if (i >= seg_cnt) return ST_NO_FIT;
    off  = seg_off[i];
    len  = seg_len[i];
    left = len - need;
    written[sidx(off)] = 1'b1;
    if (64'(left) < granule() + HEADER_BYTES) begin
      free_tot = (free_tot > len) ? free_tot - len : 0;
      size_store[sidx(off)] = len;
      drop_seg(i);
    end else begin
      free_tot = (free_tot > need) ? free_tot - need : 0;
      size_store[sidx(off)] = need;
      seg_off[i] = off + need;
      seg_len[i] = left;
    end
    ua = 32'(64'(base) + off + HEADER_BYTES);
    return ST_OK;
  endfunction

  function automatic status_e pool_free(logic [31:0] a);
    longint unsigned flr;
    logic [31:0] off, sz;
    int p;
    bit jn, jp;
    flr = 64'(base) + HEADER_BYTES;
    if (64'(a) < flr) return ST_OUTSIDE;
    off = 32'(64'(a) - flr);
    if (off >= plen) return ST_OUTSIDE;
    sz = size_store[sidx(off)];
    for (p = 0; p < seg_cnt; p++)
      if (seg_off[p] >= off) break;
    jn = (p < seg_cnt) && (64'(off) + sz == 64'(seg_off[p]));
    jp = (p > 0) && (64'(seg_off[p-1]) + seg_len[p-1] == 64'(off));
    if (!jn && !jp && seg_cnt >= MAX_SEGMENTS) return ST_FULL;
    if (jp && jn) begin
      seg_len[p-1] = sadd(sadd(seg_len[p-1], sz), seg_len[p]);
      drop_seg(p);
    end else if (jp) begin
      seg_len[p-1] = sadd(seg_len[p-1], sz);
    end else if (jn) begin
      seg_off[p] = off;
      seg_len[p] = sadd(seg_len[p], sz);
    end else begin
      for (int i = seg_cnt; i > p; i--) begin
        seg_off[i] = seg_off[i-1];
        seg_len[i] = seg_len[i-1];
      end
      seg_off[p] = off;
      seg_len[p] = sz;
      seg_cnt++;
    end
    free_tot = sadd(free_tot, sz);
    return ST_OK;
  endfunction

  function automatic result_t predict_step(op_e op, logic [16:0] req, logic [31:0] a);
    result_t r;
    r.ua = 0;
    case (op)
      OP_INIT:  r.st = pool_init();
      OP_ALLOC: r.st = pool_alloc(req, r.ua);
      OP_FREE:  r.st = pool_free(a);
      default:  r.st = ST_OK;
    endcase
    if (op == OP_ALLOC && r.st == ST_OK) begin
      last_addr = r.ua;
      live_q.push_back(r.ua);
    end
    r.fb = (free_tot > 32'h1FFFF) ? 17'h1FFFF : free_tot[16:0];
    return r;
  endfunction

  // a free address whose size entry is defined, or one the block rejects
  function automatic bit addr_legal(logic [31:0] a);
    longint unsigned flr;
    logic [31:0] off;
    flr = 64'(base) + HEADER_BYTES;
    if (64'(a) < flr) return 1;
    off = 32'(64'(a) - flr);
    return (off >= plen) || written[sidx(off)];
  endfunction

  function automatic logic [31:0] pick_free_addr();
    logic [31:0] a;
    int k, r;
    longint unsigned flr;
    r = $urandom_range(0, 99);
    if (r < 75 && live_q.size() > 0) begin
      k = $urandom_range(0, live_q.size() - 1);
      a = live_q[k];
      live_q.delete(k);
      return a;
    end
    a = (r < 88) ? $urandom() : (base + HEADER_BYTES + ($urandom_range(0, 4095) << 2));
    if (addr_legal(a)) return a;
    flr = 64'(base) + HEADER_BYTES;
    return (flr > 64'hFFFF_FFFF) ? $urandom() : $urandom_range(0, 32'(flr - 1));
  endfunction

  // sender: bursts with random gaps; gaps are taken before the next offer
  int burst_left = 0;

  task automatic send_item(op_e op, logic [16:0] req, logic [31:0] a,
                           bit typed = 0, result_t tv = '{ST_OK, 0, 0});
    result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid = 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
    end
    burst_left--;
    r = predict_step(op, req, a);
    exp_q.push_back(typed ? tv : r);
    in_valid      = 1'b1;
    opcode        = op;
    request_bytes = req;
    block_address = a;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (exp_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_e r, logic [31:0] v);
    logic [31:0] want;
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = 4'(4 * r); pwdata = v;
    @(negedge clk) penable = 1'b1;
    @(negedge clk) psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (r)
      REG_POOL_START: m_start = v;
      REG_POOL_BYTES: m_bytes = v[16:0];
      default:        m_align = v[7:0];
    endcase
    want = (r == REG_POOL_START) ? v : (r == REG_POOL_BYTES) ? {15'd0, v[16:0]} : {24'd0, v[7:0]};
    psel = 1'b1;
    @(negedge clk) penable = 1'b1;
    @(posedge clk);
    if (prdata !== want) begin
      $display("%0t: reg %0d readback expected %h actual %h", $time, r, want, prdata);
      errors++;
    end
    @(negedge clk) psel = 1'b0; penable = 1'b0;
  endtask

  task automatic setup_pool(logic [31:0] s, logic [31:0] b, logic [7:0] al);
    wait_idle();
    write_reg(REG_POOL_START, s);
    write_reg(REG_POOL_BYTES, b);
    write_reg(REG_ALIGN, {24'd0, al});
  endtask

  // receiver: stall pattern of its own plus a long hold-off on request
  initial begin
    int hold_seen, hold_left, mode, cnt;
    hold_seen = 0; hold_left = 0; mode = 0; cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (cnt == 0) begin
        mode = $urandom_range(0, 3);
        cnt  = $urandom_range(20, 120);
      end
      cnt--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        case (mode)
          0:       out_ready = 1'b1;
          1:       out_ready = 1'($urandom_range(0, 1));
          2:       out_ready = ($urandom_range(0, 4) == 0);
          default: out_ready = ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && out_ready) begin
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected result status %0d addr %h free %0d",
                 $time, status, user_address, free_bytes);
        errors++;
      end else begin
        e = exp_q.pop_front();
        checked++;
        st_hist[e.st]++;
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          errors++;
        end
        if (user_address !== e.ua) begin
          $display("%0t: user_address expected %h actual %h", $time, e.ua, user_address);
          errors++;
        end
        if (free_bytes !== e.fb) begin
          $display("%0t: free_bytes expected %0d actual %0d", $time, e.fb, free_bytes);
          errors++;
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("** first_fit_coalescing_allocator: FAILED **");
    $finish;
  end

  row_t dir_tbl [] = '{
    '{ROW_ITEM, OP_ALLOC, 17'd10,  32'd0,   ADDR_FIXED, 1, ST_NO_FIT,  0, 0},
    '{ROW_ITEM, OP_FREE,  17'd0,   32'd100, ADDR_FIXED, 1, ST_OUTSIDE, 0, 0},
    '{ROW_ITEM, OP_INIT,  17'd0,   32'd0,   ADDR_FIXED, 1, ST_SMALL,   0, 0},
    '{ROW_ITEM, OP_NOP,   17'd5,   32'd5,   ADDR_FIXED, 1, ST_OK,      0, 0},
    '{ROW_ITEM, OP_ALLOC, 17'd0,   32'd0,   ADDR_FIXED, 1, ST_ZERO,    0, 0},
    '{ROW_ITEM, OP_FREE,  17'd0,   32'd0,   ADDR_FIXED, 1, ST_OUTSIDE, 0, 0},
    '{ROW_CFG,  OP_NOP, REG_POOL_START, 32'h1001,  ADDR_FIXED, 0, ST_OK, 0, 0},
    '{ROW_CFG,  OP_NOP, REG_POOL_BYTES, 32'd65536, ADDR_FIXED, 0, ST_OK, 0, 0},
    '{ROW_CFG,  OP_NOP, REG_ALIGN,      32'd16,    ADDR_FIXED, 0, ST_OK, 0, 0},
    '{ROW_ITEM, OP_INIT,  17'd0,       32'd0,          ADDR_FIXED, 0, ST_OK, 0, 0},
    '{ROW_ITEM, OP_ALLOC, 17'd1,       32'd0,          ADDR_FIXED, 0, ST_OK, 0, 0},
    '{ROW_ITEM, OP_ALLOC, 17'd65536,   32'd0,          ADDR_FIXED, 0, ST_OK, 0, 0},
    '{ROW_ITEM, OP_ALLOC, 17'h1FFFF,   32'd0,          ADDR_FIXED, 0, ST_OK, 0, 0},
    '{ROW_ITEM, OP_FREE,  17'd0,       32'd0,          ADDR_FIXED, 0, ST_OK, 0, 0},
    '{ROW_ITEM, OP_FREE,  17'd0,       32'hFFFF_FFFF,  ADDR_FIXED, 0, ST_OK, 0, 0},
    '{ROW_ITEM, OP_FREE,  17'd0,       32'd0,          ADDR_LAST,  0, ST_OK, 0, 0},
    '{ROW_ITEM, OP_ALLOC, 17'd65500,   32'd0,          ADDR_FIXED, 0, ST_OK, 0, 0},
    '{ROW_ITEM, OP_ALLOC, 17'd1,       32'd0,          ADDR_FIXED, 0, ST_OK, 0, 0},
    '{ROW_ITEM, OP_FREE,  17'd0,       32'd0,          ADDR_LAST,  0, ST_OK, 0, 0},
    '{ROW_CFG,  OP_NOP, REG_POOL_START, 32'hFFFF_FFFF, ADDR_FIXED, 0, ST_OK, 0, 0},
    '{ROW_CFG,  OP_NOP, REG_POOL_BYTES, 32'd8,         ADDR_FIXED, 0, ST_OK, 0, 0},
    '{ROW_CFG,  OP_NOP, REG_ALIGN,      32'd0,         ADDR_FIXED, 0, ST_OK, 0, 0},
    '{ROW_ITEM, OP_INIT,  17'd0,       32'd0,          ADDR_FIXED, 0, ST_OK, 0, 0},
    '{ROW_ITEM, OP_ALLOC, 17'd1,       32'd0,          ADDR_FIXED, 0, ST_OK, 0, 0},
    '{ROW_CFG,  OP_NOP, REG_POOL_BYTES, 32'd3,         ADDR_FIXED, 0, ST_OK, 0, 0},
    '{ROW_ITEM, OP_INIT,  17'd0,       32'd0,          ADDR_FIXED, 0, ST_OK, 0, 0}
  };

  initial begin
    logic [31:0] a, s;
    logic [16:0] q;
    int r, n;
    result_t tv;
    static logic [31:0] cfg_s [7] = '{32'd0, 32'h7FFF_FFF3, 32'hFFFF_0000, 32'h12345,
                                      32'hABCD_0004, 32'd0, 32'h0};
    static logic [31:0] cfg_b [7] = '{32'd65536, 32'd4000, 32'd65536, 32'd1000,
                                      32'd20000, 32'd256, 32'h1FFFF};
    static logic [7:0]  cfg_a [7] = '{8'd4, 8'd8, 8'd1, 8'd64, 8'd32, 8'd2, 8'd128};

    for (int i = 0; i < 8; i++) st_hist[i] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(reg_e'(int'(dir_tbl[i].req)), dir_tbl[i].addr);
      end else begin
        a  = (dir_tbl[i].asel == ADDR_LAST) ? last_addr : dir_tbl[i].addr;
        tv = '{dir_tbl[i].st, dir_tbl[i].ua, dir_tbl[i].fb};
        send_item(dir_tbl[i].op, dir_tbl[i].req, a, dir_tbl[i].typed, tv);
      end
    end

    // fragmentation: isolated frees until the segment table overflows
    setup_pool(32'd0, 32'd65536, 8'd4);
    send_item(OP_INIT, 17'd0, 32'd0);
    for (int i = 0; i < 140; i++) send_item(OP_ALLOC, 17'd4, 32'd0);
    hold_req++;
    for (int i = 0; i < 70; i++) send_item(OP_FREE, 17'd0, live_q[2 * i]);
    while (live_q.size() > 0) send_item(OP_FREE, 17'd0, pick_free_addr());

    for (int ph = 0; ph < 7; ph++) begin
      s = cfg_s[ph];
      if (ph == 6) s = $urandom();
      setup_pool(s, (ph == 6) ? $urandom_range(0, 32'h1FFFF) : cfg_b[ph],
                 (ph == 6) ? 8'(1 << $urandom_range(0, 7)) : cfg_a[ph]);
      send_item(OP_INIT, 17'($urandom()), $urandom());
      if (ph == 3) hold_req++;
      n = 75;
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (r < 48) begin
          case ($urandom_range(0, 9))
            0:       q = 17'($urandom_range(0, 32'h1FFFF));
            1, 2:    q = 17'($urandom_range(1, 2000));
            3:       q = 17'($urandom_range(0, 1)) ? 17'd0 : 17'd65536;
            default: q = 17'($urandom_range(1, 64));
          endcase
          send_item(OP_ALLOC, q, $urandom());
        end else if (r < 92) begin
          send_item(OP_FREE, 17'($urandom()), pick_free_addr());
        end else if (r < 95) begin
          send_item(OP_INIT, 17'($urandom()), $urandom());
        end else begin
          send_item(OP_NOP, 17'($urandom()), $urandom());
        end
      end
    end

    while (exp_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("sent %0d transfers, checked %0d results", sent, checked);
    $display("status ok %0d zero %0d nofit %0d outside %0d full %0d small %0d",
             st_hist[0], st_hist[1], st_hist[2], st_hist[3], st_hist[4], st_hist[5]);
    if (errors == 0 && exp_q.size() == 0) begin
      $display("** first_fit_coalescing_allocator: PASSED **");
    end else begin
      $display("** first_fit_coalescing_allocator: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ffca_pkg.sv
hw/rtl/ffca_ctrl.sv
hw/rtl/ffca_dp.sv
hw/rtl/first_fit_coalescing_allocator.sv
test/first_fit_coalescing_allocator_tb.sv
